### rtl/itra_pkg.sv
// itra_pkg: shared types, constants and the microcode program for integer_to_radix_ascii.
// Used by itra_seq, itra_dpath, the top level and the checker. No dependencies.
package itra_pkg;

    localparam int unsigned VALUE_BITS_DEF = 32;
    localparam int unsigned PC_W           = 4;

    localparam logic [6:0] CH_ZERO     = 7'd48;
    localparam logic [6:0] CH_LETTER_A = 7'd65;
    localparam logic [6:0] CH_MINUS    = 7'd45;
    localparam logic [6:0] CH_NUL      = 7'd0;
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd32;
    localparam logic [5:0] DEC_RADIX   = 6'd10;
    localparam logic [4:0] DIGIT_TEN   = 5'd10;

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         radix;
    } t_itra_in;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last;
        logic       bad_radix;
    } t_itra_out;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_PUSH,
        OP_READ,
        OP_EMIT_SIGN,
        OP_EMIT_DIGIT,
        OP_EMIT_ERR
    } t_itra_op;

    typedef enum logic [3:0] {
        CD_NEVER,
        CD_ALWAYS,
        CD_IN_IDLE,
        CD_BAD_RADIX,
        CD_DIV_MORE,
        CD_QUO_NONZERO,
        CD_NOT_NEG,
        CD_OUT_BLOCKED,
        CD_DEPTH_NONZERO
    } t_itra_cond;

    typedef struct packed {
        t_itra_op            op;
        t_itra_cond          cond;
        logic [PC_W-1:0]     target;
    } t_itra_uword;

    typedef struct packed {
        logic in_valid;
        logic bad_radix;
        logic div_more;
        logic quo_nonzero;
        logic neg;
        logic out_blocked;
        logic depth_nonzero;
    } t_itra_stat;

    localparam logic [PC_W-1:0] S_WAIT      = 4'd0;
    localparam logic [PC_W-1:0] S_CHECK     = 4'd1;
    localparam logic [PC_W-1:0] S_DIV_INIT  = 4'd2;
    localparam logic [PC_W-1:0] S_DIV       = 4'd3;
    localparam logic [PC_W-1:0] S_PUSH      = 4'd4;
    localparam logic [PC_W-1:0] S_SIGN_TEST = 4'd5;
    localparam logic [PC_W-1:0] S_SIGN      = 4'd6;
    localparam logic [PC_W-1:0] S_READ      = 4'd7;
    localparam logic [PC_W-1:0] S_DIGIT     = 4'd8;
    localparam logic [PC_W-1:0] S_MORE      = 4'd9;
    localparam logic [PC_W-1:0] S_DONE      = 4'd10;
    localparam logic [PC_W-1:0] S_ERR       = 4'd11;
    localparam logic [PC_W-1:0] S_ERR_DONE  = 4'd12;

    function automatic t_itra_uword itra_ucode(input logic [PC_W-1:0] pc);
        t_itra_uword w;
        w = '{op: OP_NOP, cond: CD_ALWAYS, target: S_WAIT};
        unique case (pc)
            S_WAIT:      w = '{op: OP_LOAD,       cond: CD_IN_IDLE,       target: S_WAIT};
            S_CHECK:     w = '{op: OP_NOP,        cond: CD_BAD_RADIX,     target: S_ERR};
            S_DIV_INIT:  w = '{op: OP_DIV_START,  cond: CD_NEVER,         target: S_WAIT};
            S_DIV:       w = '{op: OP_DIV_STEP,   cond: CD_DIV_MORE,      target: S_DIV};
            S_PUSH:      w = '{op: OP_PUSH,       cond: CD_QUO_NONZERO,   target: S_DIV_INIT};
            S_SIGN_TEST: w = '{op: OP_NOP,        cond: CD_NOT_NEG,       target: S_READ};
            S_SIGN:      w = '{op: OP_EMIT_SIGN,  cond: CD_OUT_BLOCKED,   target: S_SIGN};
            S_READ:      w = '{op: OP_READ,       cond: CD_NEVER,         target: S_WAIT};
            S_DIGIT:     w = '{op: OP_EMIT_DIGIT, cond: CD_OUT_BLOCKED,   target: S_DIGIT};
            S_MORE:      w = '{op: OP_NOP,        cond: CD_DEPTH_NONZERO, target: S_READ};
            S_DONE:      w = '{op: OP_NOP,        cond: CD_ALWAYS,        target: S_WAIT};
            S_ERR:       w = '{op: OP_EMIT_ERR,   cond: CD_OUT_BLOCKED,   target: S_ERR};
            S_ERR_DONE:  w = '{op: OP_NOP,        cond: CD_ALWAYS,        target: S_WAIT};
            default:     w = '{op: OP_NOP,        cond: CD_ALWAYS,        target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

### rtl/itra_seq.sv
// itra_seq: step counter and microcode ROM; evaluates the jump condition of each step.
// Depends on itra_pkg.
module itra_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itra_pkg::t_itra_stat i_stat,
    output itra_pkg::t_itra_uword o_uword
);
    import itra_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_itra_uword     w;
    logic            taken;

    always_comb begin
        w = itra_ucode(r_pc);
    end

    always_comb begin
        unique case (w.cond)
            CD_NEVER:         taken = 1'b0;
            CD_ALWAYS:        taken = 1'b1;
            CD_IN_IDLE:       taken = !i_stat.in_valid;
            CD_BAD_RADIX:     taken = i_stat.bad_radix;
            CD_DIV_MORE:      taken = i_stat.div_more;
            CD_QUO_NONZERO:   taken = i_stat.quo_nonzero;
            CD_NOT_NEG:       taken = !i_stat.neg;
            CD_OUT_BLOCKED:   taken = i_stat.out_blocked;
            CD_DEPTH_NONZERO: taken = i_stat.depth_nonzero;
            default:          taken = 1'b1;
        endcase
        n_pc = taken ? w.target : r_pc + PC_W'(1);
    end

    always_comb begin
        o_uword = w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

### rtl/itra_dpath.sv
// itra_dpath: operand registers, shift-subtract divider, digit stack memory, output register.
// Driven by the control word from itra_seq. Depends on itra_pkg.
module itra_dpath #(
    parameter int unsigned VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  itra_pkg::t_itra_uword i_uword,
    output itra_pkg::t_itra_stat  o_stat,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  itra_pkg::t_itra_in    i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output itra_pkg::t_itra_out   o_out
);
    import itra_pkg::*;

    localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
    localparam int unsigned IDX_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] r_quo;
    logic [4:0]            r_rem;
    logic [5:0]            r_radix;
    logic                  r_neg;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_depth;
    logic [6:0]            r_stack [VALUE_BITS];
    logic [6:0]            r_rd_char;
    logic                  r_out_valid;
    t_itra_out             r_out;

    logic [VALUE_BITS-1:0] ext;
    logic                  ext_neg;
    logic [5:0]            trial;
    logic                  ge;
    logic [5:0]            diff;
    logic [6:0]            rem_char;
    logic                  blocked;
    logic                  load;
    logic [IDX_W-1:0]      rd_idx;

    always_comb begin
        ext      = VALUE_BITS'(i_in.value);
        ext_neg  = (i_in.radix == DEC_RADIX) && ext[VALUE_BITS-1];
        trial    = {r_rem, r_quo[VALUE_BITS-1]};
        ge       = trial >= r_radix;
        diff     = trial - r_radix;
        rem_char = (r_rem >= DIGIT_TEN) ? CH_LETTER_A + 7'(r_rem - DIGIT_TEN)
                                        : CH_ZERO + 7'(r_rem);
        blocked  = r_out_valid && !i_out_ready;
        load     = (i_uword.op == OP_LOAD) && i_in_valid;
        rd_idx   = IDX_W'(r_depth - CNT_W'(1));
    end

    always_comb begin
        o_in_ready           = i_uword.op == OP_LOAD;
        o_stat.in_valid      = i_in_valid;
        o_stat.bad_radix     = (r_radix < RADIX_MIN) || (r_radix > RADIX_MAX);
        o_stat.div_more      = r_cnt != CNT_W'(1);
        o_stat.quo_nonzero   = r_quo != '0;
        o_stat.neg           = r_neg;
        o_stat.out_blocked   = blocked;
        o_stat.depth_nonzero = r_depth != '0;
        o_out_valid          = r_out_valid;
        o_out                = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_radix <= i_in.radix;
            r_neg   <= ext_neg;
            r_quo   <= ext_neg ? (~ext + VALUE_BITS'(1)) : ext;
        end else if (i_uword.op == OP_DIV_START) begin
            r_rem <= '0;
            r_cnt <= CNT_W'(VALUE_BITS);
        end else if (i_uword.op == OP_DIV_STEP) begin
            r_rem <= ge ? diff[4:0] : trial[4:0];
            r_quo <= {r_quo[VALUE_BITS-2:0], ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.op == OP_PUSH) begin
            r_stack[r_depth[IDX_W-1:0]] <= rem_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.op == OP_READ) begin
            r_rd_char <= r_stack[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (load) begin
            r_depth <= '0;
        end else if (i_uword.op == OP_PUSH) begin
            r_depth <= r_depth + CNT_W'(1);
        end else if (i_uword.op == OP_READ) begin
            r_depth <= r_depth - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!blocked && (i_uword.op == OP_EMIT_SIGN || i_uword.op == OP_EMIT_DIGIT
                                  || i_uword.op == OP_EMIT_ERR)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!blocked) begin
            unique case (i_uword.op)
                OP_EMIT_SIGN:  r_out <= '{char_code: CH_MINUS, last: 1'b0, bad_radix: 1'b0};
                OP_EMIT_DIGIT: r_out <= '{char_code: r_rd_char, last: r_depth == '0,
                                          bad_radix: 1'b0};
                OP_EMIT_ERR:   r_out <= '{char_code: CH_NUL, last: 1'b1, bad_radix: 1'b1};
                default:       r_out <= r_out;
            endcase
        end
    end

endmodule

### rtl/integer_to_radix_ascii.sv
// integer_to_radix_ascii: top level, joins the microcode sequencer and the datapath.
// Depends on itra_pkg, itra_seq, itra_dpath.
//
// Converts a signed value to ASCII digits in a base from 2 to 32, most significant digit
// first, one character per output beat, the final one flagged by last. Base 10 prints a
// leading '-' for negatives; other bases read the value as unsigned VALUE_BITS bits. An
// out-of-range base gives one beat with bad_radix and last set and a NUL character. One
// conversion runs at a time. Each digit is worked out by the bit-serial divider (start,
// shift-subtract steps, push), and each character goes out through stack read, output
// load and test. The output register lets the next value be taken while the last
// character is still waiting.
module integer_to_radix_ascii #(
    parameter int unsigned VALUE_BITS = itra_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  itra_pkg::t_itra_in  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output itra_pkg::t_itra_out o_out
);
    import itra_pkg::*;

    t_itra_uword uword;
    t_itra_stat  stat;

    itra_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uword)
    );

    itra_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (uword),
        .o_stat      (stat),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

### rtl/itra_check.sv
// itra_check: port-level checks on integer_to_radix_ascii, bound to the top level.
// Depends on itra_pkg.
module itra_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input itra_pkg::t_itra_out o_out
);
    import itra_pkg::*;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.bad_radix |-> o_out.last && o_out.char_code == CH_NUL)
        else $error("error beat not last or not NUL");

    a_good_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.bad_radix |->
            (o_out.char_code >= 7'd48 && o_out.char_code <= 7'd57) ||
            (o_out.char_code >= 7'd65 && o_out.char_code <= 7'd86) ||
            o_out.char_code == CH_MINUS)
        else $error("character outside digit set");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second value taken mid conversion");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled beat changed");

endmodule

bind integer_to_radix_ascii itra_check u_itra_check (.*);
